### rtl/core/pfrgba_pkg.sv
// Package: format codes, lane control struct and a half-to-single conversion helper.
`timescale 1ns / 1ps
package pfrgba_pkg;

  typedef enum logic [2:0] {
    FMT_RGBA_HALF   = 3'd0,
    FMT_RGBA_SINGLE = 3'd1,
    FMT_SINGLE_F    = 3'd2,
    FMT_UNSIGNED_ID = 3'd3
  } fmt_t;

  localparam logic [31:0] ONE_F32_BITS = 32'h3F80_0000;
  localparam logic [7:0]  HALF_REBIAS  = 8'd112;
  localparam int unsigned NUM_LANES    = 4;

  typedef struct packed {
    logic       valid;
    logic [2:0] fmt;
    logic       row_end;
  } lane_ctl_t;

  // Half to single widening; subnormal found by a short priority search.
  // A subnormal with lz leading zeros in its 10-bit fraction has value
  // 1.f * 2^(-15 - lz), so its biased exponent is 112 - lz.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lz;
    logic [9:0]  nm;
    logic [31:0] r;
    ex  = h[14:10];
    man = h[9:0];
    lz  = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) lz = 4'(9 - i);
    end
    nm = 10'(man << (lz + 4'd1));
    if (ex == 5'd0) begin
      if (man == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], 8'(HALF_REBIAS - 8'(lz)), nm, 13'd0};
    end else if (ex == 5'h1F) begin
      r = {h[15], 8'hFF, man, 13'd0};
    end else begin
      r = {h[15], 8'(8'(ex) + HALF_REBIAS), man, 13'd0};
    end
    return r;
  endfunction

endpackage

### rtl/core/pfrgba_u2f.sv
// Unsigned 32-bit to binary32, two stages: leading-one search, then round.
`timescale 1ns / 1ps
module pfrgba_u2f (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] v,
  output logic [31:0] f
);
  import pfrgba_pkg::*;

  logic [4:0]  msb_nxt, msb_r;
  logic [31:0] v_r;
  logic        nz_r;
  logic [31:0] norm;
  logic [24:0] man;
  logic [7:0]  ex;
  logic        rnd;

  always_comb begin
    msb_nxt = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) msb_nxt = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      msb_r <= msb_nxt;
      v_r   <= v;
      nz_r  <= (v != 32'd0);
    end
  end

  // norm has the leading one at bit 31
  always_comb begin
    norm = v_r << (5'd31 - msb_r);
    rnd  = norm[7] && ((norm[6:0] != 7'd0) || norm[8]);
    man  = {1'b0, norm[31:8]} + 25'(rnd);
    ex   = 8'd127 + 8'(msb_r) + 8'(man[24]);
    if (!nz_r) f = 32'd0;
    else if (man[24]) f = {1'b0, ex, man[23:1]};
    else f = {1'b0, ex, man[22:0]};
  end
endmodule

### rtl/core/pfrgba_lane.sv
// One channel lane: half widening or pass-through, registered.
`timescale 1ns / 1ps
module pfrgba_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] word,
  output logic [31:0] half_r,
  output logic [31:0] raw_r
);
  import pfrgba_pkg::*;

  logic [31:0] half_nxt;
  assign half_nxt = half_to_single(word[15:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      half_r <= half_nxt;
      raw_r  <= word;
    end
  end
endmodule

### rtl/core/pfrgba_merge.sv
// Merge stage: picks lane results by format into the output register.
`timescale 1ns / 1ps
module pfrgba_merge (
  input  logic                  clk,
  input  logic                  en,
  input  pfrgba_pkg::lane_ctl_t ctl,
  input  logic [31:0]           half_w [4],
  input  logic [31:0]           raw_w  [4],
  input  logic [31:0]           uf,
  output logic [31:0]           o_r    [4],
  output logic                  err_r,
  output logic                  row_end_r
);
  import pfrgba_pkg::*;

  logic [31:0] o_nxt [4];
  logic        err_nxt;

  always_comb begin
    err_nxt = 1'b0;
    for (int i = 0; i < 4; i++) o_nxt[i] = 32'd0;
    unique case (ctl.fmt)
      FMT_RGBA_HALF:   for (int i = 0; i < 4; i++) o_nxt[i] = half_w[i];
      FMT_RGBA_SINGLE: for (int i = 0; i < 4; i++) o_nxt[i] = raw_w[i];
      FMT_SINGLE_F: begin
        for (int i = 0; i < 3; i++) o_nxt[i] = raw_w[0];
        o_nxt[3] = ONE_F32_BITS;
      end
      FMT_UNSIGNED_ID: begin
        for (int i = 0; i < 3; i++) o_nxt[i] = uf;
        o_nxt[3] = ONE_F32_BITS;
      end
      default: err_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r       <= o_nxt;
      err_r     <= err_nxt;
      row_end_r <= ctl.row_end;
    end
  end
endmodule

### rtl/core/pixel_format_to_rgba_float32_core.sv
// Top level: pixel format to RGBA binary32 converter with APB register.
`timescale 1ns / 1ps
// Pipeline: the lane/search stage, then the merge and rounding stage into
// the output register.
// Throughput: one pixel per cycle; the pipeline only stalls when the
// output is held by out_ready low.
// Reset: synchronous active-low rst_n clears valids and pixel_format to 0.
module pixel_format_to_rgba_float32_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_src_chan_0,
  input  logic [31:0] in_src_chan_1,
  input  logic [31:0] in_src_chan_2,
  input  logic [31:0] in_src_chan_3,
  input  logic        in_row_end_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_out_red,
  output logic [31:0] out_out_green,
  output logic [31:0] out_out_blue,
  output logic [31:0] out_out_alpha,
  output logic        out_format_error,
  output logic        out_row_end_out
);
  import pfrgba_pkg::*;

  logic [2:0] fmt_r;
  lane_ctl_t  s1_r;
  logic       s2_v_r;
  logic       adv;

  // whole pipe moves when the output slot is free or being taken
  assign adv      = !s2_v_r || out_ready;
  assign in_ready = adv;
  assign pready   = 1'b1;
  assign prdata   = (paddr == 2'd0) ? {29'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= 3'd0;
      s1_r   <= '0;
      s2_v_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) fmt_r <= pwdata[2:0];
      if (adv) begin
        s1_r   <= '{valid: in_valid, fmt: fmt_r, row_end: in_row_end_in};
        s2_v_r <= s1_r.valid;
      end
    end
  end

  logic [31:0] words  [4];
  logic [31:0] half_w [4];
  logic [31:0] raw_w  [4];
  logic [31:0] uf;
  logic [31:0] o_w    [4];

  assign words[0] = in_src_chan_0;
  assign words[1] = in_src_chan_1;
  assign words[2] = in_src_chan_2;
  assign words[3] = in_src_chan_3;

  // four lanes side by side, one per channel word
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pfrgba_lane u_lane (
      .clk(clk), .en(adv), .word(words[g]), .half_r(half_w[g]), .raw_r(raw_w[g])
    );
  end

  pfrgba_u2f u_u2f (.clk(clk), .en(adv), .v(in_src_chan_0), .f(uf));

  pfrgba_merge u_merge (
    .clk(clk), .en(adv), .ctl(s1_r), .half_w(half_w), .raw_w(raw_w), .uf(uf),
    .o_r(o_w), .err_r(out_format_error), .row_end_r(out_row_end_out)
  );

  assign out_valid     = s2_v_r;
  assign out_out_red   = o_w[0];
  assign out_out_green = o_w[1];
  assign out_out_blue  = o_w[2];
  assign out_out_alpha = o_w[3];
endmodule

### verif/pixel_convert_checker.sv
// Checker: predicts each converted pixel and compares it with the block's output.
`timescale 1ns / 1ps
module pixel_convert_checker
  import pfrgba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_src_chan_0,
  input  logic [31:0] in_src_chan_1,
  input  logic [31:0] in_src_chan_2,
  input  logic [31:0] in_src_chan_3,
  input  logic        in_row_end_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_out_red,
  input  logic [31:0] out_out_green,
  input  logic [31:0] out_out_blue,
  input  logic [31:0] out_out_alpha,
  input  logic        out_format_error,
  input  logic        out_row_end_out,
  output int          fail_count,
  output int          pixels_pending
);

  typedef struct {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
    logic        fmt_err;
    logic        row_end;
  } rgba_pixel_t;

  rgba_pixel_t expected_pixels[$];
  logic [2:0]  cur_format;

  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [4:0]  ex;
    logic [10:0] man;
    int          shifts;
    ex     = h[14:10];
    man    = {1'b0, h[9:0]};
    shifts = 0;
    if (ex == 5'd0) begin
      if (man == 11'd0) return {h[15], 31'd0};
      while (!man[10]) begin
        man = man << 1;
        shifts++;
      end
      return {h[15], 8'(113 - shifts), man[9:0], 13'd0};
    end
    if (ex == 5'h1F) return {h[15], 8'hFF, man[9:0], 13'd0};
    return {h[15], 8'(ex + 112), man[9:0], 13'd0};
  endfunction

  // Unsigned to binary32, round to nearest, ties to even
  function automatic logic [31:0] uint_to_f32(input logic [31:0] v);
    int          msb;
    int          sh;
    logic [31:0] man;
    logic [31:0] rem;
    logic [31:0] halfway;
    msb = 31;
    if (v == 32'd0) return 32'd0;
    while (!v[msb]) msb--;
    if (msb <= 23) begin
      man = v << (23 - msb);
    end else begin
      sh      = msb - 23;
      rem     = v & ((32'd1 << sh) - 32'd1);
      halfway = 32'd1 << (sh - 1);
      man     = v >> sh;
      if (rem > halfway || (rem == halfway && man[0])) begin
        man = man + 32'd1;
        if (man == 32'h0100_0000) begin
          man = man >> 1;
          msb++;
        end
      end
    end
    return {1'b0, 8'(127 + msb), man[22:0]};
  endfunction

  function automatic rgba_pixel_t predict_pixel(input logic [2:0] fmt,
      input logic [31:0] c0, c1, c2, c3, input logic re);
    rgba_pixel_t p;
    logic [31:0] v;
    p = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0, re};
    case (fmt)
      FMT_RGBA_HALF: begin
        p.red   = widen_half(c0[15:0]);
        p.green = widen_half(c1[15:0]);
        p.blue  = widen_half(c2[15:0]);
        p.alpha = widen_half(c3[15:0]);
      end
      FMT_RGBA_SINGLE: begin
        p.red = c0; p.green = c1; p.blue = c2; p.alpha = c3;
      end
      FMT_SINGLE_F: begin
        p.red = c0; p.green = c0; p.blue = c0; p.alpha = ONE_F32_BITS;
      end
      FMT_UNSIGNED_ID: begin
        v = uint_to_f32(c0);
        p.red = v; p.green = v; p.blue = v; p.alpha = ONE_F32_BITS;
      end
      default: p.fmt_err = 1'b1;
    endcase
    return p;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  assign pixels_pending = expected_pixels.size();

  always @(posedge clk) begin
    rgba_pixel_t e;
    if (!rst_n) begin
      cur_format <= FMT_RGBA_HALF;
      expected_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got red %h",
                   $time, out_out_red);
          fail_count++;
        end else begin
          e = expected_pixels.pop_front();
          check_field("red",       e.red,     out_out_red);
          check_field("green",     e.green,   out_out_green);
          check_field("blue",      e.blue,    out_out_blue);
          check_field("alpha",     e.alpha,   out_out_alpha);
          check_field("fmt_error", 32'(e.fmt_err), 32'(out_format_error));
          check_field("row_end",   32'(e.row_end), 32'(out_row_end_out));
        end
      end
      if (in_valid && in_ready)
        expected_pixels.push_back(predict_pixel(cur_format, in_src_chan_0, in_src_chan_1,
                                                in_src_chan_2, in_src_chan_3, in_row_end_in));
      if (psel && penable && pwrite && pready && paddr == 2'd0)
        cur_format <= pwdata[2:0];
    end
  end

endmodule

### verif/tb_pixel_format_to_rgba_float32_core.sv
// Testbench top: stimulus, APB format writes and verdict for the pixel converter.
`timescale 1ns / 1ps
module tb_pixel_format_to_rgba_float32_core;
  import pfrgba_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 56;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  // APB side, idle from time zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  // pixel channels
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_src_chan_0 = 32'd0;
  logic [31:0] in_src_chan_1 = 32'd0;
  logic [31:0] in_src_chan_2 = 32'd0;
  logic [31:0] in_src_chan_3 = 32'd0;
  logic        in_row_end_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_out_red, out_out_green, out_out_blue, out_out_alpha;
  logic        out_format_error, out_row_end_out;

  int fail_count;
  int pixels_pending;
  int send_idle = 28;  // percent of cycles the sender holds off
  int recv_idle = 66;  // percent of cycles the receiver stalls
  int cycles = 0;

  always #6 clk = ~clk;

  pixel_format_to_rgba_float32_core uut (.*);

  pixel_convert_checker chk (.*);

  // Receiver back-pressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // Watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Present one pixel and hold it until the transaction completes.
  // in_ready is looked at on the falling edge, well clear of the update.
  task automatic send_pixel(input logic [31:0] c0, c1, c2, c3, input logic re);
    in_valid      <= 1'b1;
    in_src_chan_0 <= c0;
    in_src_chan_1 <= c1;
    in_src_chan_2 <= c2;
    in_src_chan_3 <= c3;
    in_row_end_in <= re;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Let the pipe empty, then allow for the two-stage latency
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup then access; upper data bits are junk on purpose
  task automatic write_format(input logic [2:0] fmt);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 2'd0;
    pwdata  <= {29'($urandom_range(0, 32'h1FFF_FFFF)), fmt};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Random half with the exponent steered towards zero and all-ones now and then
  function automatic logic [31:0] rand_half_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(3))
      0: w[14:10] = 5'd0;
      1: w[14:10] = 5'h1F;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_word(input logic [2:0] fmt);
    if (fmt == FMT_RGBA_HALF) return rand_half_word();
    if (fmt == FMT_UNSIGNED_ID) return $urandom >> $urandom_range(31);
    return $urandom;
  endfunction

  initial begin
    logic [2:0] phase_fmt [8] = '{3'd0, 3'd3, 3'd1, 3'd2, 3'd7, 3'd3, 3'd0, 3'd4};
    logic [2:0] f;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: half widening from the reset format (zeros, subnormals, inf, NaN)
    send_pixel(32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_03FF, 1'b0);
    send_pixel(32'hFFFF_8200, 32'hABCD_7C00, 32'h0000_FC00, 32'h0000_7E01, 1'b1);
    send_pixel(32'h0000_7C01, 32'h0000_3C00, 32'h0000_7BFF, 32'h0000_0400, 1'b0);
    send_pixel(32'hFFFF_FFFF, 32'h0000_8001, 32'h0001_0200, 32'h0000_FFFF, 1'b1);
    drain();

    write_format(FMT_RGBA_SINGLE);
    send_pixel(32'hFFFF_FFFF, 32'h7F80_0001, 32'h8000_0000, 32'h0000_0001, 1'b1);
    send_pixel(32'h0000_0000, 32'h3F80_0000, 32'hFFC0_0000, 32'h7F7F_FFFF, 1'b0);
    drain();

    // Single float: signalling NaN must pass untouched, other channels ignored
    write_format(FMT_SINGLE_F);
    send_pixel(32'h7F80_0001, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1);
    send_pixel(32'h0000_0000, 32'hDEAD_BEEF, 32'h0, 32'h0, 1'b0);
    drain();

    // Unsigned id: exact range, ties both ways, carry into the exponent
    write_format(FMT_UNSIGNED_ID);
    send_pixel(32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
    send_pixel(32'h0000_0001, 32'h0, 32'h0, 32'h0, 1'b1);
    send_pixel(32'h00FF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
    send_pixel(32'h0100_0001, 32'h0, 32'h0, 32'h0, 1'b0);
    send_pixel(32'h0100_0003, 32'h0, 32'h0, 32'h0, 1'b0);
    send_pixel(32'h0100_0002, 32'h0, 32'h0, 32'h0, 1'b1);
    send_pixel(32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
    drain();

    // Unsupported codes give zeros and the error flag
    write_format(3'd5);
    send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    drain();

    // Random phases; idling pattern changes every few phases
    for (int ph = 0; ph < 8; ph++) begin
      f = phase_fmt[ph];
      if (ph < 3) begin
        send_idle = 28; recv_idle = 66;
      end else if (ph < 6) begin
        send_idle = 66; recv_idle = 28;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      write_format(f);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender holds off once mid-phase until the pipe is empty
        if (ph == 2 && i == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pixels_pending != 0) @(posedge clk);
        end
        send_pixel(rand_word(f), rand_word(f), rand_word(f), rand_word(f),
                   1'($urandom_range(1)));
      end
      drain();
    end

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
